FILE: hdl/cts_pkg.sv
`timescale 1ns / 1ps

package cts_pkg;

  localparam int CMD_W  = 3;
  localparam int TGT_W  = 4;
  localparam int STAT_W = 3;
  localparam int TID_W  = 4;
  localparam int RCNT_W = 5;

  // command codes
  localparam logic [CMD_W-1:0] CMD_SPAWN    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_YIELD    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_JOIN     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_EXIT     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_DISPATCH = 3'd4;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK          = 3'd0;
  localparam logic [STAT_W-1:0] ST_RUN_OVER    = 3'd1;
  localparam logic [STAT_W-1:0] ST_TABLE_FULL  = 3'd2;
  localparam logic [STAT_W-1:0] ST_TARGET_DEAD = 3'd3;
  localparam logic [STAT_W-1:0] ST_NO_TASK     = 3'd4;
  localparam logic [STAT_W-1:0] ST_BAD_TARGET  = 3'd5;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [TGT_W-1:0] target_task;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] result_status;
    logic [TID_W-1:0]  task_id;
    logic [TID_W-1:0]  running_task;
    logic [RCNT_W-1:0] ready_count;
  } res_t;

  typedef struct packed {
    logic push;
    logic pop;
    logic clear;
  } q_ctrl_t;

endpackage

FILE: hdl/cts_if.sv
`timescale 1ns / 1ps

interface cts_cmd_if
  import cts_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] cmd;
  logic [TGT_W-1:0] target_task;

  modport source (output valid, output cmd, output target_task, input ready);
  modport sink (input valid, input cmd, input target_task, output ready);
endinterface

interface cts_res_if
  import cts_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] result_status;
  logic [TID_W-1:0]  task_id;
  logic [TID_W-1:0]  running_task;
  logic [RCNT_W-1:0] ready_count;

  modport source (output valid, output result_status, output task_id, output running_task,
                  output ready_count, input ready);
  modport sink (input valid, input result_status, input task_id, input running_task,
                input ready_count, output ready);
endinterface

FILE: hdl/cts_ram.sv
`timescale 1ns / 1ps

module cts_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/cts_run_queue.sv
`timescale 1ns / 1ps

module cts_run_queue
  import cts_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  q_ctrl_t                            ctrl,
  input  logic [$clog2(MAX_TASKS)-1:0]       push_id,
  output logic [$clog2(MAX_TASKS)-1:0]       head_id,
  output logic [$clog2(MAX_TASKS+1)-1:0]     count,
  output logic [$clog2(MAX_TASKS+1)-1:0]     count_after
);

  localparam int ID_W  = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  logic [ID_W-1:0]  head_r, head_nxt;
  logic [ID_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             byp_v_r;
  logic [ID_W-1:0]  byp_d_r;
  logic [ID_W-1:0]  ram_rdata;
  logic             full;
  logic             wr_en;

  function automatic logic [ID_W-1:0] ptr_inc(input logic [ID_W-1:0] p);
    return (p == ID_W'(MAX_TASKS - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full  = (count_r == CNT_W'(MAX_TASKS));
  // drop a push into a full queue
  assign wr_en = ctrl.push && !full && !ctrl.clear;

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (ctrl.clear) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end else begin
      if (wr_en) begin
        tail_nxt  = ptr_inc(tail_r);
        count_nxt = count_r + 1'b1;
      end
      if (ctrl.pop) begin
        head_nxt  = ptr_inc(head_r);
        count_nxt = count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
      byp_v_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      // RAM reads old data when the new head is written in the same cycle
      byp_v_r <= wr_en && (tail_r == head_nxt);
    end
  end

  always_ff @(posedge clk) begin
    byp_d_r <= push_id;
  end

  // prefetch the word at the next head so a pop needs no separate RAM read
  cts_ram #(
    .WIDTH (ID_W),
    .DEPTH (MAX_TASKS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (tail_r),
    .wdata (push_id),
    .raddr (head_nxt),
    .rdata (ram_rdata)
  );

  assign head_id     = byp_v_r ? byp_d_r : ram_rdata;
  assign count       = count_r;
  assign count_after = count_nxt;

endmodule

FILE: hdl/cts_engine.sv
`timescale 1ns / 1ps

module cts_engine
  import cts_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           exec,
  input  cmd_t                           item,
  output res_t                           res,
  output q_ctrl_t                        q_ctrl,
  output logic [$clog2(MAX_TASKS)-1:0]   q_push_id,
  input  logic [$clog2(MAX_TASKS)-1:0]   q_head_id,
  input  logic [$clog2(MAX_TASKS+1)-1:0] q_count,
  input  logic [$clog2(MAX_TASKS+1)-1:0] q_count_after
);

  localparam int ID_W   = $clog2(MAX_TASKS);
  localparam int CNT_W  = $clog2(MAX_TASKS + 1);
  // only ids within the join target range can ever be joined
  localparam int SPAN   = (MAX_TASKS < (1 << TGT_W)) ? MAX_TASKS : (1 << TGT_W);
  localparam int SPAN_W = $clog2(SPAN);
  localparam int SLOTS  = 1 << SPAN_W;
  localparam int CMP_W  = (CNT_W > TGT_W + 1) ? CNT_W : TGT_W + 1;

  logic [ID_W-1:0]   cur_r, cur_nxt;
  logic [CNT_W-1:0]  next_id_r, next_id_nxt;
  logic [SLOTS-1:0]  dead_r, dead_nxt;
  logic [SLOTS-1:0]  jw_v_r, jw_v_nxt;
  logic [ID_W-1:0]   jw_r [SLOTS];
  logic              jw_we;

  logic [STAT_W-1:0] status_c;
  logic [ID_W-1:0]   tid_c;
  q_ctrl_t           ctrl_c;
  logic [ID_W-1:0]   push_id_c;

  logic [SPAN_W-1:0] tgt_idx;
  logic [SPAN_W-1:0] cur_idx;
  logic [CMP_W-1:0]  tgt_w;
  logic              cur_zero;
  logic              cur_in_span;
  logic              tgt_bad;

  assign tgt_idx     = item.target_task[SPAN_W-1:0];
  assign cur_idx     = cur_r[SPAN_W-1:0];
  assign tgt_w       = CMP_W'(item.target_task);
  assign cur_zero    = (cur_r == '0);
  assign cur_in_span = (CMP_W'(cur_r) < CMP_W'(SPAN));
  // a target not yet spawned in this run is still free
  assign tgt_bad     = (item.target_task == '0) || (tgt_w >= CMP_W'(MAX_TASKS)) ||
                       (tgt_w == CMP_W'(cur_r)) || (tgt_w >= CMP_W'(next_id_r));

  always_comb begin
    status_c    = ST_OK;
    tid_c       = '0;
    cur_nxt     = cur_r;
    next_id_nxt = next_id_r;
    dead_nxt    = dead_r;
    jw_v_nxt    = jw_v_r;
    jw_we       = 1'b0;
    ctrl_c      = '0;
    push_id_c   = '0;
    unique case (item.cmd)
      CMD_SPAWN: begin
        if (next_id_r >= CNT_W'(MAX_TASKS)) begin
          status_c = ST_TABLE_FULL;
        end else begin
          tid_c       = next_id_r[ID_W-1:0];
          ctrl_c.push = 1'b1;
          push_id_c   = next_id_r[ID_W-1:0];
          next_id_nxt = next_id_r + 1'b1;
        end
      end
      CMD_YIELD: begin
        if (cur_zero) begin
          status_c = ST_NO_TASK;
        end else begin
          ctrl_c.push = 1'b1;
          push_id_c   = cur_r;
          cur_nxt     = '0;
        end
      end
      CMD_JOIN: begin
        if (cur_zero) begin
          status_c = ST_NO_TASK;
        end else if (tgt_bad) begin
          status_c = ST_BAD_TARGET;
        end else if (dead_r[tgt_idx]) begin
          status_c = ST_TARGET_DEAD;
        end else begin
          // a later joiner replaces the earlier one
          jw_we             = 1'b1;
          jw_v_nxt[tgt_idx] = 1'b1;
          cur_nxt           = '0;
        end
      end
      CMD_EXIT: begin
        if (cur_zero) begin
          status_c = ST_NO_TASK;
        end else begin
          if (cur_in_span) begin
            dead_nxt[cur_idx] = 1'b1;
            if (jw_v_r[cur_idx]) begin
              tid_c             = jw_r[cur_idx];
              ctrl_c.push       = 1'b1;
              push_id_c         = jw_r[cur_idx];
              jw_v_nxt[cur_idx] = 1'b0;
            end
          end
          cur_nxt = '0;
        end
      end
      CMD_DISPATCH: begin
        if (!cur_zero) begin
          status_c = ST_OK;
        end else if (q_count == '0) begin
          // run over: wipe the table and restart ids
          status_c     = ST_RUN_OVER;
          ctrl_c.clear = 1'b1;
          dead_nxt     = '0;
          jw_v_nxt     = '0;
          next_id_nxt  = CNT_W'(1);
        end else begin
          tid_c      = q_head_id;
          ctrl_c.pop = 1'b1;
          cur_nxt    = q_head_id;
        end
      end
      default: begin
        status_c = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r     <= '0;
      next_id_r <= CNT_W'(1);
      dead_r    <= '0;
      jw_v_r    <= '0;
    end else if (exec) begin
      cur_r     <= cur_nxt;
      next_id_r <= next_id_nxt;
      dead_r    <= dead_nxt;
      jw_v_r    <= jw_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec && jw_we) begin
      jw_r[tgt_idx] <= cur_r;
    end
  end

  assign q_ctrl    = exec ? ctrl_c : '0;
  assign q_push_id = push_id_c;

  assign res.result_status = status_c;
  assign res.task_id       = TID_W'(tid_c);
  assign res.running_task  = TID_W'(cur_nxt);
  assign res.ready_count   = RCNT_W'(q_count_after);

endmodule

FILE: hdl/cooperative_task_scheduler_top.sv
`timescale 1ns / 1ps
// A command word is taken into the input register, executed, and its result word presented from the result register.
// Throughput: one command word per cycle while the result side does not stall; the single execute stage between the
// input register and the result register sets this, the run-queue RAM being prefetched.
// Reset: synchronous, active low; clears the task table, queue pointers and current task.
// Run-queue RAM contents are left as they are and need no clearing pass.
module cooperative_task_scheduler_top
  import cts_pkg::*;
#(
  parameter int MAX_TASKS = 16
) (
  input logic       clk,
  input logic       rst_n,
  cts_cmd_if.sink   in_ch,
  cts_res_if.source out_ch
);

  localparam int ID_W  = $clog2(MAX_TASKS);
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  logic             in_v_r;
  cmd_t             in_d_r;
  logic             out_v_r;
  res_t             out_d_r;
  logic             adv;
  res_t             res;
  q_ctrl_t          q_ctrl;
  logic [ID_W-1:0]  q_push_id;
  logic [ID_W-1:0]  q_head_id;
  logic [CNT_W-1:0] q_count;
  logic [CNT_W-1:0] q_count_after;

  // execute the held word when the result register is free or being drained
  assign adv         = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_v_r <= in_ch.valid;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_d_r.cmd         <= in_ch.cmd;
      in_d_r.target_task <= in_ch.target_task;
    end
    if (adv) begin
      out_d_r <= res;
    end
  end

  cts_engine #(
    .MAX_TASKS (MAX_TASKS)
  ) u_engine (
    .clk           (clk),
    .rst_n         (rst_n),
    .exec          (adv),
    .item          (in_d_r),
    .res           (res),
    .q_ctrl        (q_ctrl),
    .q_push_id     (q_push_id),
    .q_head_id     (q_head_id),
    .q_count       (q_count),
    .q_count_after (q_count_after)
  );

  cts_run_queue #(
    .MAX_TASKS (MAX_TASKS)
  ) u_run_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (q_ctrl),
    .push_id     (q_push_id),
    .head_id     (q_head_id),
    .count       (q_count),
    .count_after (q_count_after)
  );

  assign out_ch.valid         = out_v_r;
  assign out_ch.result_status = out_d_r.result_status;
  assign out_ch.task_id       = out_d_r.task_id;
  assign out_ch.running_task  = out_d_r.running_task;
  assign out_ch.ready_count   = out_d_r.ready_count;

  a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_v_r && !adv |=> in_v_r && $stable(in_d_r))
    else $error("held command word lost or changed");

  a_dispatch_runs: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (in_d_r.cmd == CMD_DISPATCH) && (res.result_status == ST_OK) &&
    (res.task_id != '0) |-> res.running_task == res.task_id)
    else $error("dispatched task is not the running task");

  a_run_over: assert property (@(posedge clk) disable iff (!rst_n)
    adv && (res.result_status == ST_RUN_OVER) |->
    (res.ready_count == '0) && (res.running_task == '0))
    else $error("run over left tasks behind");

  a_no_double_q_op: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({q_ctrl.push, q_ctrl.pop, q_ctrl.clear}) <= 1)
    else $error("more than one run-queue operation in a cycle");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import cts_pkg::*;

  localparam int NTASK      = 16;
  localparam int N_RANDOM   = 1900;
  localparam int MAX_CYCLES = 400000;
  localparam int HOLD_LEN   = 300;
  localparam int NDIR       = 27;

  localparam logic [4:0] NO_WAITER = 5'd16;

  // a code the block decodes as no operation
  localparam logic [CMD_W-1:0] CMD_NONE_HI = 3'd7;

  typedef enum logic [2:0] {
    TS_FREE, TS_READY, TS_RUNNING, TS_WAITING, TS_DEAD
  } task_state_e;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [TGT_W-1:0] tgt;
    logic [4:0]       reps;
    logic             typed;
    res_t             res;
  } dir_row_t;

  localparam res_t FROM_MODEL = '0;

  // rows with typed = 0 are checked against the scheduler model
  localparam dir_row_t DIR_TAB [NDIR] = '{
    {CMD_YIELD,    4'd0,  5'd1,  1'b1, ST_NO_TASK,     4'd0, 4'd0, 5'd0},
    {CMD_JOIN,     4'd3,  5'd1,  1'b1, ST_NO_TASK,     4'd0, 4'd0, 5'd0},
    {CMD_EXIT,     4'd0,  5'd1,  1'b1, ST_NO_TASK,     4'd0, 4'd0, 5'd0},
    {CMD_DISPATCH, 4'd0,  5'd1,  1'b1, ST_RUN_OVER,    4'd0, 4'd0, 5'd0},
    {CMD_NONE_HI,  4'd15, 5'd1,  1'b1, ST_OK,          4'd0, 4'd0, 5'd0},
    {CMD_SPAWN,    4'd0,  5'd1,  1'b1, ST_OK,          4'd1, 4'd0, 5'd1},
    {CMD_SPAWN,    4'd15, 5'd1,  1'b1, ST_OK,          4'd2, 4'd0, 5'd2},
    {CMD_DISPATCH, 4'd0,  5'd1,  1'b0, FROM_MODEL},
    {CMD_DISPATCH, 4'd9,  5'd1,  1'b0, FROM_MODEL},
    {CMD_JOIN,     4'd0,  5'd1,  1'b1, ST_BAD_TARGET,  4'd0, 4'd1, 5'd1},
    {CMD_JOIN,     4'd1,  5'd1,  1'b0, FROM_MODEL},
    {CMD_JOIN,     4'd15, 5'd1,  1'b1, ST_BAD_TARGET,  4'd0, 4'd1, 5'd1},
    {CMD_JOIN,     4'd2,  5'd1,  1'b0, FROM_MODEL},
    {CMD_DISPATCH, 4'd0,  5'd1,  1'b0, FROM_MODEL},
    {CMD_EXIT,     4'd0,  5'd1,  1'b0, FROM_MODEL},
    {CMD_DISPATCH, 4'd0,  5'd1,  1'b0, FROM_MODEL},
    {CMD_JOIN,     4'd2,  5'd1,  1'b0, FROM_MODEL},
    {CMD_YIELD,    4'd0,  5'd1,  1'b0, FROM_MODEL},
    {CMD_SPAWN,    4'd0,  5'd13, 1'b0, FROM_MODEL},
    {CMD_SPAWN,    4'd0,  5'd1,  1'b1, ST_TABLE_FULL,  4'd0, 4'd0, 5'd14},
    {CMD_DISPATCH, 4'd0,  5'd1,  1'b0, FROM_MODEL},
    {CMD_JOIN,     4'd3,  5'd1,  1'b0, FROM_MODEL},
    {CMD_DISPATCH, 4'd0,  5'd1,  1'b0, FROM_MODEL},
    {CMD_YIELD,    4'd0,  5'd1,  1'b0, FROM_MODEL},
    {CMD_DISPATCH, 4'd0,  5'd1,  1'b0, FROM_MODEL},
    {CMD_JOIN,     4'd3,  5'd1,  1'b0, FROM_MODEL},
    {CMD_DISPATCH, 4'd0,  5'd1,  1'b0, FROM_MODEL}
  };

  logic clk;
  logic rst_n;

  cts_cmd_if in_ch ();
  cts_res_if out_ch ();

  cooperative_task_scheduler_top #(.MAX_TASKS(NTASK)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // scheduler model state
  task_state_e tstate [NTASK];
  logic [4:0]  waiter [NTASK];
  logic [3:0]  ready_q [$];
  logic [3:0]  cur;
  logic [4:0]  next_id;

  res_t sched_exp_q [$];
  res_t pend_res;
  int   errors;
  bit   tx_calm;
  bit   rx_calm;

  function automatic void sched_clear();
    for (int i = 0; i < NTASK; i++) begin
      tstate[i] = TS_FREE;
      waiter[i] = NO_WAITER;
    end
    ready_q.delete();
    cur     = 4'd0;
    next_id = 5'd1;
  endfunction

  function automatic void queue_id(logic [3:0] id);
    // drop on a full queue
    if (ready_q.size() < NTASK) ready_q.push_back(id);
  endfunction

  function automatic res_t sched_predict(logic [CMD_W-1:0] c, logic [TGT_W-1:0] t);
    res_t       r;
    logic [4:0] w;
    r = '0;
    r.result_status = ST_OK;
    case (c)
      CMD_SPAWN: begin
        if (next_id >= NTASK) begin
          r.result_status = ST_TABLE_FULL;
        end else begin
          r.task_id = next_id[3:0];
          tstate[next_id[3:0]] = TS_READY;
          waiter[next_id[3:0]] = NO_WAITER;
          queue_id(next_id[3:0]);
          next_id = next_id + 5'd1;
        end
      end
      CMD_YIELD: begin
        if (cur == 4'd0) begin
          r.result_status = ST_NO_TASK;
        end else begin
          tstate[cur] = TS_READY;
          queue_id(cur);
          cur = 4'd0;
        end
      end
      CMD_JOIN: begin
        if (cur == 4'd0) begin
          r.result_status = ST_NO_TASK;
        end else if (t == 4'd0 || t == cur || tstate[t] == TS_FREE) begin
          r.result_status = ST_BAD_TARGET;
        end else if (tstate[t] == TS_DEAD) begin
          r.result_status = ST_TARGET_DEAD;
        end else begin
          // a later joiner replaces the earlier one
          tstate[cur] = TS_WAITING;
          waiter[t]   = {1'b0, cur};
          cur         = 4'd0;
        end
      end
      CMD_EXIT: begin
        if (cur == 4'd0) begin
          r.result_status = ST_NO_TASK;
        end else begin
          w = waiter[cur];
          tstate[cur] = TS_DEAD;
          if (w < NTASK) begin
            tstate[w[3:0]] = TS_READY;
            queue_id(w[3:0]);
            r.task_id   = w[3:0];
            waiter[cur] = NO_WAITER;
          end
          cur = 4'd0;
        end
      end
      CMD_DISPATCH: begin
        if (cur == 4'd0) begin
          if (ready_q.size() == 0) begin
            r.result_status = ST_RUN_OVER;
            sched_clear();
          end else begin
            r.task_id = ready_q.pop_front();
            tstate[r.task_id] = TS_RUNNING;
            cur = r.task_id;
          end
        end
      end
      default: begin
      end
    endcase
    r.running_task = cur;
    r.ready_count  = 5'(ready_q.size());
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    errors++;
    $display("%0t: %s: got %0d, want %0d", $time, what, got, want);
  endtask

  task automatic send_word(logic [CMD_W-1:0] c, logic [TGT_W-1:0] t, logic typed, res_t fixed);
    int   gap;
    res_t p;
    gap = tx_calm ? 0 : $urandom_range(0, 18);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    p = sched_predict(c, t);
    pend_res = typed ? fixed : p;
    in_ch.valid       <= 1'b1;
    in_ch.cmd         <= c;
    in_ch.target_task <= t;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // bias towards command sequences that make sense for the current state
  task automatic pick_word(output logic [CMD_W-1:0] c, output logic [TGT_W-1:0] t);
    int r;
    r = $urandom_range(0, 99);
    t = TGT_W'($urandom_range(0, 15));
    if (r < 8) begin
      c = CMD_W'($urandom_range(0, 7));
    end else if (cur == 4'd0) begin
      if (next_id >= NTASK) c = (r < 15) ? CMD_SPAWN : CMD_DISPATCH;
      else if (ready_q.size() == 0) c = (r < 70) ? CMD_SPAWN : CMD_DISPATCH;
      else c = (r < 45) ? CMD_SPAWN : CMD_DISPATCH;
    end else begin
      if (r < 40) c = CMD_YIELD;
      else if (r < 65) c = CMD_JOIN;
      else if (r < 85) c = CMD_EXIT;
      else c = CMD_SPAWN;
      if (c == CMD_JOIN && next_id > 5'd1 && $urandom_range(0, 4) != 0)
        t = TGT_W'($urandom_range(1, next_id - 1));
    end
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    int cyc;
    cyc = 0;
    while (cyc < MAX_CYCLES) begin
      @(posedge clk);
      cyc++;
    end
    $display("** cooperative_task_scheduler_top: FAILED **");
    $finish;
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (sched_exp_q.size() == 0) begin
        report_mismatch("unexpected result word status", int'(out_ch.result_status), 0);
      end else begin
        want = sched_exp_q.pop_front();
        if (out_ch.result_status !== want.result_status)
          report_mismatch("result_status", int'(out_ch.result_status),
                          int'(want.result_status));
        if (out_ch.task_id !== want.task_id)
          report_mismatch("task_id", int'(out_ch.task_id), int'(want.task_id));
        if (out_ch.running_task !== want.running_task)
          report_mismatch("running_task", int'(out_ch.running_task),
                          int'(want.running_task));
        if (out_ch.ready_count !== want.ready_count)
          report_mismatch("ready_count", int'(out_ch.ready_count), int'(want.ready_count));
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) sched_exp_q.push_back(pend_res);
  end

  // result side: random stalls, calm stretches and two long hold-offs
  initial begin
    int gap;
    int seen;
    seen = 0;
    rx_calm = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (seen == 400 || seen == 1300) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
        repeat (HOLD_LEN) @(negedge clk);
      end
      rx_calm = ((seen / 170) % 3 == 2);
      gap = rx_calm ? 0 : $urandom_range(0, 18);
      repeat (gap) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      seen++;
    end
  end

  initial begin
    logic [CMD_W-1:0] c;
    logic [TGT_W-1:0] t;
    int               n;
    errors = 0;
    tx_calm = 1'b0;
    pend_res = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_SPAWN;
    in_ch.target_task = 4'd0;
    rst_n = 1'b0;
    sched_clear();
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < NDIR; i++)
      for (int k = 0; k < DIR_TAB[i].reps; k++)
        send_word(DIR_TAB[i].cmd, DIR_TAB[i].tgt, DIR_TAB[i].typed, DIR_TAB[i].res);

    n = 0;
    while (n < N_RANDOM) begin
      if (n == 900) begin
        // hold off until every result is back
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (sched_exp_q.size() != 0) @(negedge clk);
        n++;
      end
      tx_calm = ((n / 150) % 3 == 1);
      pick_word(c, t);
      // ignored words do not advance the count
      if (!(c > CMD_DISPATCH || (c == CMD_DISPATCH && cur != 4'd0))) n++;
      send_word(c, t, 1'b0, FROM_MODEL);
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sched_exp_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (errors == 0) begin
      $display("** cooperative_task_scheduler_top: PASSED **");
    end else begin
      $display("** cooperative_task_scheduler_top: FAILED **");
    end
    $finish;
  end

endmodule
